[rtl/set_assoc_cache_lru_lookup_assert.svh]
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SACL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sacl_pkg.sv]
package sacl_pkg;

   localparam int DEF_MAX_SETS = 512;
   localparam int DEF_MAX_WAYS = 8;

   localparam int REQ_DATA_W = 32;
   localparam int TAG_W      = 32;
   localparam int STAMP_W    = 32;
   localparam int CNT_W      = 32;
   localparam int WAY_OUT_W  = 3;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;
   // index_bits reaches 15, so the raw set field is at most 15 bits
   localparam int FIELD_W    = 15;

   // result tdata layout
   localparam int HIT_LSB    = 0;
   localparam int WAY_LSB    = 1;
   localparam int ACC_LSB    = WAY_LSB + WAY_OUT_W;
   localparam int MISS_LSB   = ACC_LSB + CNT_W;
   localparam int RSP_USED_W = MISS_LSB + CNT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd6;
   localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd6;
   localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_READ,
      ST_LOOKUP,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

[rtl/set_assoc_cache_lru_lookup.sv]
// Tag directory of a set-associative cache with least-recently-used replacement.
// req channel: one 32-bit byte address per transfer. rsp channel: one result per
// address with hit flag, way used, and running access and miss counts (32-bit wrap).
// csr port: csr_we writes csr_wdata to offset_bits (0), index_bits (1) or
// ways_in_use (2); write only while no lookup is in flight.
// Each lookup runs these steps before the next req transfer: split of set and
// tag, set index reduction modulo MAX_SETS (two multiply stages), one read of the
// set row from the directory RAM, tag compare and LRU pick, then write-back of the
// row. The result is registered in the same cycle as the row write-back.
// The whole set (valid, tag, stamp of every way) is one RAM row, so a lookup is one
// read and one write of the same row; lookups never overlap, so no forwarding.
// After reset the block sweeps the RAM and clears every row; req_tready stays low
// meanwhile. Counters, CSRs and the result valid flag take reset values.
// The result sits in an output register: while rsp_tready is low the next address
// can still be taken and processed up to its write-back, which then waits.
module set_assoc_cache_lru_lookup import sacl_pkg::*; #(
   parameter int MAX_SETS = DEF_MAX_SETS,
   parameter int MAX_WAYS = DEF_MAX_WAYS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // address
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // hit, way_used, access_count, miss_count
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int TREE_N  = 1 << WAY_W;
   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int SET_LOG = $clog2(MAX_SETS);
   localparam int SHIFT   = FIELD_W + SET_LOG;
   localparam int RECIP_W = FIELD_W + 2;
   localparam int RECIP   = ((1 << SHIFT) + MAX_SETS - 1) / MAX_SETS;
   localparam int PROD_W  = FIELD_W + RECIP_W;
   localparam int REM_W   = FIELD_W + SET_W + 1;
   localparam int ROW_W   = MAX_WAYS * $bits(entry_type);
   localparam int LIVE_W  = CFG_W + 1;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]   offset_ff, index_ff, ways_ff;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [FIELD_W-1:0] quot_ff, quot_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [SET_W-1:0]   clr_ff, clr_in;
   logic               hit_ff, hit_in;
   logic [WAY_W-1:0]   way_ff, way_in;
   logic [CNT_W-1:0]   access_ff, access_in;
   logic [CNT_W-1:0]   miss_ff, miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               ram_wr_en, ram_rd_en;
   logic [SET_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ROW_W-1:0]   ram_wr_data, ram_rd_data;

   entry_type [MAX_WAYS-1:0] row, row_new;

   logic [REQ_DATA_W-1:0] addr_shifted;
   logic [FIELD_W-1:0]    idx_mask;
   logic [PROD_W-1:0]     prod;
   logic [REM_W-1:0]      rem;
   logic [LIVE_W-1:0]     live;
   logic [MAX_WAYS-1:0]   active, hit_vec, inv_vec;
   logic [WAY_W-1:0]      hit_way, inv_way;
   logic                  rsp_free;
   logic [CNT_W-1:0]      access_next, miss_next;

   logic                  node_ok    [2*TREE_N];
   logic [STAMP_W-1:0]    node_stamp [2*TREE_N];
   logic [WAY_W-1:0]      node_way   [2*TREE_N];

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_SETS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // set field and tag split straight off the incoming address
   always_comb begin
      addr_shifted = req_tdata >> offset_ff;
      idx_mask     = ~({FIELD_W{1'b1}} << index_ff);
      field_in     = addr_shifted[FIELD_W-1:0] & idx_mask;
      tag_in       = req_tdata >> ({1'b0, offset_ff} + {1'b0, index_ff});
   end

   // set = field mod MAX_SETS via exact reciprocal, then one multiply-subtract
   always_comb begin
      prod    = PROD_W'(field_ff) * PROD_W'(RECIP_W'(RECIP));
      quot_in = FIELD_W'(prod >> SHIFT);
      rem     = REM_W'(field_ff) - REM_W'(quot_ff) * REM_W'(MAX_SETS);
      set_in  = rem[SET_W-1:0];
   end

   // way search on the row read back from the RAM
   always_comb begin
      row = ram_rd_data;
      if (ways_ff == '0) begin
         live = LIVE_W'(1);
      end else if ({1'b0, ways_ff} > LIVE_W'(MAX_WAYS)) begin
         live = LIVE_W'(MAX_WAYS);
      end else begin
         live = {1'b0, ways_ff};
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         active[w]  = LIVE_W'(w) < live;
         hit_vec[w] = active[w] && row[w].valid && (row[w].tag == tag_ff);
         inv_vec[w] = active[w] && !row[w].valid;
      end
      hit_way = '0;
      inv_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (inv_vec[w]) begin
            inv_way = WAY_W'(w);
         end
      end
      // oldest-stamp tournament, left side wins ties so the lower way is kept
      for (int n = 0; n < 2 * TREE_N; n++) begin
         node_ok[n]    = 1'b0;
         node_stamp[n] = '0;
         node_way[n]   = '0;
      end
      for (int i = 0; i < TREE_N; i++) begin
         node_way[TREE_N + i] = WAY_W'(i);
         if (i < MAX_WAYS) begin
            node_ok[TREE_N + i]    = active[i];
            node_stamp[TREE_N + i] = row[i].stamp;
         end
      end
      for (int n = TREE_N - 1; n >= 1; n--) begin
         if (!node_ok[2*n] ||
             (node_ok[2*n+1] && (node_stamp[2*n+1] < node_stamp[2*n]))) begin
            node_ok[n]    = node_ok[2*n+1];
            node_stamp[n] = node_stamp[2*n+1];
            node_way[n]   = node_way[2*n+1];
         end else begin
            node_ok[n]    = node_ok[2*n];
            node_stamp[n] = node_stamp[2*n];
            node_way[n]   = node_way[2*n];
         end
      end
      hit_in = |hit_vec;
      if (|hit_vec) begin
         way_in = hit_way;
      end else if (|inv_vec) begin
         way_in = inv_way;
      end else begin
         way_in = node_way[1];
      end
   end

   // write-back row and result; a hit rewrites the same tag, so both cases match
   always_comb begin
      row_new                = row;
      row_new[way_ff].valid  = 1'b1;
      row_new[way_ff].tag    = tag_ff;
      row_new[way_ff].stamp  = access_ff;
      access_next            = access_ff + CNT_W'(1);
      miss_next              = miss_ff + CNT_W'(!hit_ff);
      rsp_data_in            = '0;
      rsp_data_in[HIT_LSB]                = hit_ff;
      rsp_data_in[WAY_LSB +: WAY_OUT_W]   = WAY_OUT_W'(way_ff);
      rsp_data_in[ACC_LSB +: CNT_W]       = access_next;
      rsp_data_in[MISS_LSB +: CNT_W]      = miss_next;
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      access_in    = access_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = set_ff;
      ram_wr_data  = row_new;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = set_in;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SET_W'(1);
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) begin
               ram_wr_en    = 1'b1;
               access_in    = access_next;
               miss_in      = miss_next;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OFFSET_BITS_RST;
         index_ff     <= INDEX_BITS_RST;
         ways_ff      <= WAYS_IN_USE_RST;
         clr_ff       <= '0;
         access_ff    <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         access_ff    <= access_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_addr))
               CSR_OFFSET_BITS: offset_ff <= csr_wdata;
               CSR_INDEX_BITS:  index_ff  <= csr_wdata;
               CSR_WAYS_IN_USE: ways_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         field_ff <= field_in;
         tag_ff   <= tag_in;
      end
      if (state_ff == ST_SCALE) begin
         quot_ff <= quot_in;
      end
      if (state_ff == ST_READ) begin
         set_ff <= set_in;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_ff <= hit_in;
         way_ff <= way_in;
      end
      if (state_ff == ST_WRITE && rsp_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/sacl_ram.sv]
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sacl_checker.sv]
`include "set_assoc_cache_lru_lookup_assert.svh"

module sacl_checker import sacl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] miss_ff, miss_in;
   logic [CNT_W-1:0] acc_exp, miss_exp;
   logic             rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign acc_exp  = acc_ff + CNT_W'(1);
   assign miss_exp = miss_ff + CNT_W'(!rsp_tdata[HIT_LSB]);

   always_comb begin
      acc_in  = acc_ff;
      miss_in = miss_ff;
      if (rsp_xfer) begin
         acc_in  = rsp_tdata[ACC_LSB +: CNT_W];
         miss_in = rsp_tdata[MISS_LSB +: CNT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         miss_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         miss_ff <= miss_in;
      end
   end

   // directory clear runs right after reset, no address taken
   `SACL_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), !req_tready, "address taken during clear")

   `SACL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // every result counts exactly one more access than the one before
   `SACL_ASSERT_NOW(a_access_step, clock, reset, rsp_xfer, rsp_tdata[ACC_LSB +: CNT_W] == acc_exp, "access count skipped")

   `SACL_ASSERT_NOW(a_miss_step, clock, reset, rsp_xfer, rsp_tdata[MISS_LSB +: CNT_W] == miss_exp, "miss count off")

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (.*);

[test/set_assoc_cache_lru_lookup_tb.sv]
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_tb;
   import sacl_pkg::*;

   localparam int MAX_SETS    = DEF_MAX_SETS;
   localparam int MAX_WAYS    = DEF_MAX_WAYS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic [CNT_W-1:0]     accesses;
      logic [CNT_W-1:0]     misses;
   } lookup_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // directory as the block should hold it
   logic                dir_valid [MAX_SETS][MAX_WAYS];
   logic [TAG_W-1:0]    dir_tag   [MAX_SETS][MAX_WAYS];
   logic [STAMP_W-1:0]  dir_stamp [MAX_SETS][MAX_WAYS];
   logic [CNT_W-1:0]    access_total = '0;
   logic [CNT_W-1:0]    miss_total = '0;
   logic [CFG_W-1:0]    cfg_offset = OFFSET_BITS_RST;
   logic [CFG_W-1:0]    cfg_index  = INDEX_BITS_RST;
   logic [CFG_W-1:0]    cfg_ways   = WAYS_IN_USE_RST;

   lookup_result_type pending_lookups [$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             sender_calm = 1'b0;
   bit             receiver_calm = 1'b0;
   int             stall_left = 0;
   int             calm_left = 0;

   always #5 clock = ~clock;

   set_assoc_cache_lru_lookup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // address
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // hit, way_used, access_count, miss_count
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   task automatic lookup_directory(input logic [31:0] addr, output lookup_result_type res);
      logic [63:0]        field;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
      int                 set_idx;
      int                 nways;
      int                 chosen;
      int                 oldest;
      int                 w;
      bit                 hit;
      bit                 filled;
      field   = ({32'd0, addr} >> cfg_offset) & ((64'd1 << cfg_index) - 64'd1);
      set_idx = int'(field % MAX_SETS);
      // tag shift can reach 30, so keep the sum out of 4-bit arithmetic
      tag     = 32'({32'd0, addr} >> (int'(cfg_offset) + int'(cfg_index)));
      if (cfg_ways == 0)
         nways = 1;
      else if (cfg_ways > MAX_WAYS)
         nways = MAX_WAYS;
      else
         nways = int'(cfg_ways);
      stamp  = access_total;
      hit    = 1'b0;
      chosen = 0;
      for (w = 0; w < nways; w++) begin
         if (dir_valid[set_idx][w] && dir_tag[set_idx][w] == tag) begin
            hit    = 1'b1;
            chosen = w;
            dir_stamp[set_idx][w] = stamp;
            break;
         end
      end
      if (!hit) begin
         filled = 1'b0;
         oldest = 0;
         miss_total++;
         for (w = 0; w < nways; w++) begin
            if (!dir_valid[set_idx][w]) begin
               filled = 1'b1;
               chosen = w;
               break;
            end
            if (dir_stamp[set_idx][w] < dir_stamp[set_idx][oldest])
               oldest = w;
         end
         if (!filled)
            chosen = oldest;
         dir_valid[set_idx][chosen] = 1'b1;
         dir_tag[set_idx][chosen]   = tag;
         dir_stamp[set_idx][chosen] = stamp;
      end
      access_total++;
      res.hit      = hit;
      res.way      = 3'(chosen);
      res.accesses = access_total;
      res.misses   = miss_total;
   endtask

   function automatic int pick_gap();
      int roll;
      if (sender_calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] compose_address(input logic [31:0] tag,
                                                   input logic [31:0] set_field,
                                                   input logic [31:0] low);
      logic [63:0] a;
      a = ({32'd0, tag} << (int'(cfg_offset) + int'(cfg_index)))
        | (({32'd0, set_field} & ((64'd1 << cfg_index) - 64'd1)) << cfg_offset)
        | ({32'd0, low} & ((64'd1 << cfg_offset) - 64'd1));
      return a[31:0];
   endfunction

   // valid stays high across back-to-back transfers
   task automatic send_address(input logic [31:0] addr);
      lookup_result_type want;
      int             gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      lookup_directory(addr, want);
      pending_lookups.push_back(want);
   endtask

   task automatic drain_lookups();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] idx,
                               input logic [CFG_W-1:0] ways);
      drain_lookups();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_OFFSET_BITS;
      csr_wdata <= off;
      @(posedge clock);
      csr_addr  <= CSR_INDEX_BITS;
      csr_wdata <= idx;
      @(posedge clock);
      csr_addr  <= CSR_WAYS_IN_USE;
      csr_wdata <= ways;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_offset  = off;
      cfg_index   = idx;
      cfg_ways    = ways;
      @(posedge clock);
   endtask

   task automatic test_reset_geometry();
      send_address(32'h0000_0000);
      send_address(32'h0000_0000);
      send_address(32'h0000_0040);
      // same set, other tag, single way: replaces way 0
      send_address(32'h0000_1000);
      send_address(32'hFFFF_FFFF);
   endtask

   task automatic test_lru_replacement();
      set_geometry(4'd4, 4'd2, 4'd4);
      send_address(compose_address(32'd1, 32'd1, 32'd0));
      send_address(compose_address(32'd2, 32'd1, 32'd3));
      send_address(compose_address(32'd3, 32'd1, 32'd5));
      send_address(compose_address(32'd4, 32'd1, 32'd15));
      send_address(compose_address(32'd1, 32'd1, 32'd7));
      send_address(compose_address(32'd2, 32'd1, 32'd0));
      // tag 3 is now the least recently used
      send_address(compose_address(32'd5, 32'd1, 32'd0));
   endtask

   task automatic test_way_clamping();
      int n;
      set_geometry(4'd4, 4'd2, 4'd0);
      send_address(compose_address(32'd7, 32'd0, 32'd0));
      send_address(compose_address(32'd8, 32'd0, 32'd0));
      set_geometry(4'd4, 4'd2, 4'd15);
      for (n = 0; n < 9; n++)
         send_address(compose_address(32'd100 + n, 32'd2, 32'd0));
   endtask

   task automatic test_large_shifts();
      set_geometry(4'd15, 4'd15, 4'd2);
      send_address(32'h0000_8000);
      // set field 513 folds onto set 1 with the same tag
      send_address(32'h0100_8000);
      set_geometry(4'd0, 4'd0, 4'd1);
      send_address(32'hA5A5_5A5A);
   endtask

   task automatic test_random_traffic();
      logic [31:0] tag_pool [10];
      logic [31:0] set_pool [3];
      int          phase;
      int          n;
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_geometry(4'd12, 4'd9, 4'd8);
            1: set_geometry(4'd0, 4'd0, 4'd1);
            2: set_geometry(4'd15, 4'd15, 4'd15);
            3: set_geometry(4'd0, 4'd9, 4'd0);
            4: set_geometry(OFFSET_BITS_RST, INDEX_BITS_RST, WAYS_IN_USE_RST);
            default: set_geometry(CFG_W'($urandom_range(0, 15)),
                                  CFG_W'($urandom_range(0, 15)),
                                  CFG_W'($urandom_range(0, 15)));
         endcase
         sender_calm = (phase % 3 == 1);
         foreach (tag_pool[i]) tag_pool[i] = $urandom;
         foreach (set_pool[i]) set_pool[i] = $urandom;
         for (n = 0; n < 70; n++) begin
            if ($urandom_range(0, 99) < 80)
               send_address(compose_address(tag_pool[$urandom_range(0, 9)],
                                            set_pool[$urandom_range(0, 2)], $urandom));
            else
               send_address($urandom);
         end
      end
      sender_calm = 1'b0;
   endtask

   // result side: random stalls, alternating with calm stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!receiver_calm && $urandom_range(0, 5) == 0)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
      if (calm_left == 0) begin
         receiver_calm <= ~receiver_calm;
         calm_left     <= $urandom_range(20, 300);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tdata[HIT_LSB] !== want.hit)
               report_mismatch("hit", 32'(rsp_tdata[HIT_LSB]), 32'(want.hit));
            if (rsp_tdata[WAY_LSB +: WAY_OUT_W] !== want.way)
               report_mismatch("way_used", 32'(rsp_tdata[WAY_LSB +: WAY_OUT_W]),
                               32'(want.way));
            if (rsp_tdata[ACC_LSB +: CNT_W] !== want.accesses)
               report_mismatch("access_count", rsp_tdata[ACC_LSB +: CNT_W], want.accesses);
            if (rsp_tdata[MISS_LSB +: CNT_W] !== want.misses)
               report_mismatch("miss_count", rsp_tdata[MISS_LSB +: CNT_W], want.misses);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (dir_valid[s, w]) dir_valid[s][w] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // the block clears its directory before taking transfers
      while (!req_tready) @(posedge clock);

      test_reset_geometry();
      test_lru_replacement();
      test_way_clamping();
      test_large_shifts();
      test_random_traffic();

      drain_lookups();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
